// File: rtl/core/assert_macros.svh
// Concurrent assertion helpers, sampled on clk_i and disabled during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that an expression holds at every clock edge.
`define LPDC_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a consequent holds in the same cycle as its antecedent.
`define LPDC_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check that a consequent holds in the cycle after its antecedent.
`define LPDC_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/lpdc_pkg.sv
package lpdc_pkg;

  localparam int unsigned LEVELS      = 8;
  localparam int unsigned QUEUE_DEPTH = 8;

  localparam int unsigned POS_W  = 3;
  localparam int unsigned QD_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W  = 4;
  localparam int unsigned DBNC_W = 8;
  localparam int unsigned SENS_W = 8;
  localparam int unsigned LED_W  = 8;

  localparam logic [DBNC_W-1:0] DBNC_RST = 8'd24;
  localparam logic [DBNC_W-1:0] LT_MAX   = 8'hFF;
  localparam logic [POS_W-1:0]  LVL_TOP  = POS_W'(LEVELS - 1);
  localparam logic [CNT_W-1:0]  Q_FULL   = CNT_W'(QUEUE_DEPTH);

  localparam int unsigned S_TDATA_W = 16;
  localparam int unsigned S_TUSER_W = 2;
  localparam int unsigned M_TDATA_W = 24;

  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_ENQ   = 2'd1,
    KIND_CLEAR = 2'd2
  } kind_e;

endpackage

// File: rtl/core/lift_position_and_drive_control.sv
// Channel   Dir  Width  Fields (lowest bit first)
// s_axis    in   16/2   tdata: sensors[7:0] target_level[10:8]; tuser: kind[1:0]
// m_axis    out  24     tdata: motor_run motor_up level_leds[7:0] pos_from[2:0]
//                              pos_to[2:0] queue_count[3:0] arrived request_dropped
// cfg       in   8      debounce_ticks, written when cfg_we_i is high
//
// One beat per cycle sustained while m_axis keeps accepting result beats.
// An input register feeds one pass of level, queue and motor logic into the result register.
// The input register takes a new beat while it is empty or when it empties in the same cycle.
// Reset clears control state, counters, positions and the queue; queue entries are not cleared.
// A stalled m_axis holds its beat; the input side stalls only once both registers are full.
module lift_position_and_drive_control
  import lpdc_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [DBNC_W-1:0]    cfg_wdata_i,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  // sensors[7:0], target_level[10:8], zero[15:11]
  input  logic [S_TDATA_W-1:0] s_axis_tdata_i,
  // kind[1:0]
  input  logic [S_TUSER_W-1:0] s_axis_tuser_i,
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  // motor_run[0], motor_up[1], level_leds[9:2], pos_from[12:10], pos_to[15:13],
  // queue_count[19:16], arrived[20], request_dropped[21], zero[23:22]
  output logic [M_TDATA_W-1:0] m_axis_tdata_o
);

  logic                in_vld_q;
  logic [1:0]          in_kind_q;
  logic [SENS_W-1:0]   in_sens_q;
  logic [POS_W-1:0]    in_tgt_q;
  logic                out_vld_q;
  logic [M_TDATA_W-1:0] out_data_q, out_data_d;
  logic                advance;

  logic [DBNC_W-1:0]   dbnc_q;
  logic [DBNC_W-1:0]   low_time_q [LEVELS];
  logic [DBNC_W-1:0]   low_time_d [LEVELS];
  logic [LEVELS-1:0]   at_lvl_q, at_lvl_d;
  logic [POS_W-1:0]    pos_from_q, pos_from_d;
  logic [POS_W-1:0]    pos_to_q, pos_to_d;
  logic                dir_up_q, dir_up_d;
  logic                run_q, run_d;
  logic [QD_W-1:0]     head_q, head_d;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [POS_W-1:0]    mem_q [QUEUE_DEPTH];
  logic                mem_we;
  logic [QD_W-1:0]     tail;
  logic [CNT_W:0]      tail_sum;
  logic                arrived, dropped;
  logic [LED_W-1:0]    leds;

  assign advance         = in_vld_q && (!out_vld_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_vld_q || advance;
  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_data_q;

  always_comb begin
    tail_sum = (CNT_W + 1)'(head_q) + (CNT_W + 1)'(count_q);
    if (tail_sum >= (CNT_W + 1)'(QUEUE_DEPTH)) begin
      tail_sum = tail_sum - (CNT_W + 1)'(QUEUE_DEPTH);
    end
    tail = tail_sum[QD_W-1:0];
  end

  always_comb begin
    logic [POS_W-1:0]  pf, pt, ref_lvl, h;
    logic              dir;
    logic [DBNC_W:0]   n;
    pf         = pos_from_q;
    pt         = pos_to_q;
    dir        = dir_up_q;
    run_d      = run_q;
    head_d     = head_q;
    count_d    = count_q;
    at_lvl_d   = at_lvl_q;
    low_time_d = low_time_q;
    arrived    = 1'b0;
    dropped    = 1'b0;
    mem_we     = 1'b0;
    h          = mem_q[head_q];
    ref_lvl    = pf;
    n          = '0;
    case (in_kind_q)
      KIND_TICK: begin
        for (int i = 0; i < LEVELS; i++) begin
          if (!in_sens_q[i]) begin
            n = {1'b0, low_time_q[i]} + 1'b1;
            if (n > {1'b0, dbnc_q} && !at_lvl_q[i]) begin
              at_lvl_d[i] = 1'b1;
              pf          = POS_W'(i);
              pt          = POS_W'(i);
            end
            low_time_d[i] = n[DBNC_W] ? LT_MAX : n[DBNC_W-1:0];
          end else begin
            if (at_lvl_q[i]) begin
              if (pt == '0) begin
                dir = 1'b1;
              end else if (pt == LVL_TOP) begin
                dir = 1'b0;
              end
              if (dir) begin
                pt = (pf < LVL_TOP) ? pf + 1'b1 : LVL_TOP;
              end else begin
                pt = (pf > '0) ? pf - 1'b1 : '0;
              end
            end
            at_lvl_d[i]   = 1'b0;
            low_time_d[i] = '0;
          end
        end
        if (count_q != '0) begin
          if (pf == pt && !in_sens_q[h]) begin
            run_d   = 1'b0;
            head_d  = (head_q == QD_W'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
            count_d = count_q - 1'b1;
            arrived = 1'b1;
          end else begin
            ref_lvl = (pf > pt) ? pt : pf;
            if (h > ref_lvl) begin
              dir = 1'b1;
            end else if (h < ref_lvl) begin
              dir = 1'b0;
            end
            run_d = 1'b1;
          end
        end
      end
      KIND_ENQ: begin
        if (in_tgt_q <= LVL_TOP) begin
          if (count_q >= Q_FULL) begin
            dropped = 1'b1;
          end else begin
            mem_we  = 1'b1;
            count_d = count_q + 1'b1;
          end
        end
      end
      KIND_CLEAR: begin
        head_d  = '0;
        count_d = '0;
      end
      default: begin
      end
    endcase
    pos_from_d = pf;
    pos_to_d   = pt;
    dir_up_d   = dir;
    leds       = (LED_W'(1) << pf) | (LED_W'(1) << pt);
    out_data_d = {2'b00, dropped, arrived, count_d, pt, pf, leds, dir, run_d};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q   <= 1'b0;
      out_vld_q  <= 1'b0;
      dbnc_q     <= DBNC_RST;
      low_time_q <= '{default: '0};
      at_lvl_q   <= '0;
      pos_from_q <= '0;
      pos_to_q   <= '0;
      dir_up_q   <= 1'b0;
      run_q      <= 1'b0;
      head_q     <= '0;
      count_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        dbnc_q <= cfg_wdata_i;
      end
      if (s_axis_tready_o) begin
        in_vld_q <= s_axis_tvalid_i;
      end
      if (advance) begin
        out_vld_q  <= 1'b1;
        low_time_q <= low_time_d;
        at_lvl_q   <= at_lvl_d;
        pos_from_q <= pos_from_d;
        pos_to_q   <= pos_to_d;
        dir_up_q   <= dir_up_d;
        run_q      <= run_d;
        head_q     <= head_d;
        count_q    <= count_d;
      end else if (m_axis_tready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_kind_q <= s_axis_tuser_i;
      in_sens_q <= s_axis_tdata_i[SENS_W-1:0];
      in_tgt_q  <= s_axis_tdata_i[SENS_W +: POS_W];
    end
    if (advance) begin
      out_data_q <= out_data_d;
    end
    if (advance && mem_we) begin
      mem_q[tail] <= in_tgt_q;
    end
  end

endmodule

// File: rtl/core/lpdc_checker.sv
`include "assert_macros.svh"

module lpdc_checker
  import lpdc_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 cfg_we_i,
  input logic [DBNC_W-1:0]    cfg_wdata_i,
  input logic                 s_axis_tvalid_i,
  input logic                 s_axis_tready_o,
  input logic [S_TDATA_W-1:0] s_axis_tdata_i,
  input logic [S_TUSER_W-1:0] s_axis_tuser_i,
  input logic                 m_axis_tvalid_o,
  input logic                 m_axis_tready_i,
  input logic [M_TDATA_W-1:0] m_axis_tdata_o
);

  logic             run_o;
  logic [LED_W-1:0] leds_o;
  logic [POS_W-1:0] from_o, to_o;
  logic [CNT_W-1:0] count_o;
  logic             arrived_o, dropped_o;
  logic             unused_in;

  assign run_o     = m_axis_tdata_o[0];
  assign leds_o    = m_axis_tdata_o[9:2];
  assign from_o    = m_axis_tdata_o[12:10];
  assign to_o      = m_axis_tdata_o[15:13];
  assign count_o   = m_axis_tdata_o[19:16];
  assign arrived_o = m_axis_tdata_o[20];
  assign dropped_o = m_axis_tdata_o[21];
  assign unused_in = cfg_we_i ^ (^cfg_wdata_i) ^ s_axis_tvalid_i ^ s_axis_tready_o
                     ^ (^s_axis_tdata_i) ^ (^s_axis_tuser_i);

  `LPDC_ASSERT_NEXT(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o && $stable(m_axis_tdata_o) && (unused_in || !unused_in), "result beat changed while stalled")
  `LPDC_ASSERT_IMPL(a_count_max, m_axis_tvalid_o, count_o <= Q_FULL, "queue count above depth")
  `LPDC_ASSERT_IMPL(a_flags_excl, m_axis_tvalid_o, !(arrived_o && dropped_o), "arrival and drop in one beat")
  `LPDC_ASSERT_IMPL(a_arrive_stop, m_axis_tvalid_o && arrived_o, !run_o && from_o == to_o, "arrival with motor running or cabin between levels")
  `LPDC_ASSERT_IMPL(a_leds_rest, m_axis_tvalid_o && from_o == to_o, $onehot(leds_o), "resting cabin lights other than one level")

endmodule

bind lift_position_and_drive_control lpdc_checker u_lpdc_checker (.*);

// File: tb/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import lpdc_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 90;
  localparam int HOLD_AFTER     = 140;
  localparam int MAX_REPORTS    = 10;
  localparam logic [1:0] KIND_RSVD = 2'd3;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_MOSTLY, RX_PERIODIC} rx_mode_e;

  typedef struct packed {
    logic [1:0]        kind;
    logic [SENS_W-1:0] sensors;
    logic [POS_W-1:0]  target;
  } beat_t;

  typedef struct packed {
    logic [1:0]       pad;
    logic             dropped;
    logic             arrived;
    logic [CNT_W-1:0] qcount;
    logic [POS_W-1:0] pos_to;
    logic [POS_W-1:0] pos_from;
    logic [LED_W-1:0] leds;
    logic             motor_up;
    logic             motor_run;
  } status_t;

  logic                 clk_i     = 1'b0;
  logic                 rst_ni    = 1'b0;
  logic                 cfg_we    = 1'b0;
  logic [DBNC_W-1:0]    cfg_wdata = '0;
  logic                 s_valid   = 1'b0;
  logic                 s_ready;
  logic [S_TDATA_W-1:0] s_tdata   = '0;
  logic [S_TUSER_W-1:0] s_tuser   = '0;
  logic                 m_valid;
  logic                 m_ready   = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;

  always #10 clk_i = ~clk_i;

  lift_position_and_drive_control u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_tdata)
  );

  // lift state as the block should hold it
  logic [DBNC_W-1:0] dbnc_m = DBNC_RST;
  logic [DBNC_W-1:0] lt_m [LEVELS] = '{default: '0};
  logic              at_m [LEVELS] = '{default: 1'b0};
  logic [POS_W-1:0]  from_m = '0;
  logic [POS_W-1:0]  to_m   = '0;
  logic              up_m   = 1'b0;
  logic              run_m  = 1'b0;
  logic [POS_W-1:0]  fifo_m [QUEUE_DEPTH] = '{default: '0};
  logic [QD_W-1:0]   head_m = '0;
  logic [CNT_W-1:0]  cnt_m  = '0;

  beat_t   pending_beats[$];
  status_t want_status_q[$];
  beat_t   cur;
  bit      beat_done;
  int      queued_total, beats_in, results_out, arrivals, drops, cfg_writes;
  int      err_cnt, idle_cyc, stall_run, stall_max;
  int      burst_left = 1;
  int      gap_left;
  int      rx_cyc, hold_left;
  bit      hold_done;
  rx_mode_e rx_mode = RX_OPEN;
  int      cab;
  int      route[$];

  task automatic advance_lift(input beat_t b);
    status_t          r;
    logic [DBNC_W:0]  n;
    logic [POS_W-1:0] h;
    logic [POS_W-1:0] ref_lvl;
    r = '0;
    if (b.kind == KIND_TICK) begin
      for (int i = 0; i < LEVELS; i++) begin
        if (i < SENS_W && !b.sensors[i]) begin
          n = {1'b0, lt_m[i]} + 1'b1;
          if (n > {1'b0, dbnc_m} && !at_m[i]) begin
            at_m[i] = 1'b1;
            from_m  = POS_W'(i);
            to_m    = POS_W'(i);
          end
          lt_m[i] = (n > {1'b0, LT_MAX}) ? LT_MAX : n[DBNC_W-1:0];
        end else begin
          if (at_m[i]) begin
            if (to_m == '0) up_m = 1'b1;
            else if (to_m == LVL_TOP) up_m = 1'b0;
            if (up_m) to_m = (from_m < LVL_TOP) ? from_m + 1'b1 : LVL_TOP;
            else to_m = (from_m > '0) ? from_m - 1'b1 : '0;
          end
          at_m[i] = 1'b0;
          lt_m[i] = '0;
        end
      end
      if (cnt_m > 0) begin
        h = fifo_m[head_m];
        if (from_m == to_m && int'(h) < SENS_W && !b.sensors[h]) begin
          run_m     = 1'b0;
          head_m    = QD_W'((int'(head_m) + 1) % QUEUE_DEPTH);
          cnt_m     = cnt_m - 1'b1;
          r.arrived = 1'b1;
        end else begin
          ref_lvl = (from_m > to_m) ? to_m : from_m;
          if (h > ref_lvl) up_m = 1'b1;
          else if (h < ref_lvl) up_m = 1'b0;
          run_m = 1'b1;
        end
      end
    end else if (b.kind == KIND_ENQ) begin
      if (int'(b.target) < LEVELS) begin
        if (cnt_m >= QUEUE_DEPTH) begin
          r.dropped = 1'b1;
        end else begin
          fifo_m[QD_W'((int'(head_m) + int'(cnt_m)) % QUEUE_DEPTH)] = b.target;
          cnt_m = cnt_m + 1'b1;
        end
      end
    end else if (b.kind == KIND_CLEAR) begin
      head_m = '0;
      cnt_m  = '0;
    end
    r.motor_run        = run_m;
    r.motor_up         = up_m;
    r.leds[from_m]     = 1'b1;
    r.leds[to_m]       = 1'b1;
    r.pos_from         = from_m;
    r.pos_to           = to_m;
    r.qcount           = cnt_m;
    want_status_q.push_back(r);
  endtask

  function automatic void put(logic [1:0] k, logic [SENS_W-1:0] s, logic [POS_W-1:0] t);
    beat_t b;
    b.kind    = k;
    b.sensors = s;
    b.target  = t;
    pending_beats.push_back(b);
    queued_total++;
  endfunction

  // cabin rides level to level, mostly toward the oldest request it knows of
  task automatic run_trips(input int n_items);
    int stop_at, r, dwell;
    logic [SENS_W-1:0] s;
    stop_at = queued_total + n_items;
    while (queued_total < stop_at) begin
      r = $urandom_range(0, 99);
      if (r < 15) begin
        s = SENS_W'($urandom);
        put(KIND_ENQ, SENS_W'($urandom), s[POS_W-1:0]);
        if (route.size() < QUEUE_DEPTH) route.push_back(int'(s[POS_W-1:0]));
      end else if (r < 18) begin
        put(KIND_CLEAR, SENS_W'($urandom), POS_W'($urandom));
        route.delete();
      end else if (r < 20) begin
        put(KIND_RSVD, SENS_W'($urandom), POS_W'($urandom));
      end else if (r < 26) begin
        repeat ($urandom_range(1, 3)) put(KIND_TICK, SENS_W'($urandom), POS_W'($urandom));
      end else begin
        dwell = int'(dbnc_m) + $urandom_range(0, 3);
        repeat (dwell) begin
          s = ~(SENS_W'(1) << cab);
          if ($urandom_range(0, 9) == 0) s[$urandom_range(0, SENS_W - 1)] = 1'b0;
          if ($urandom_range(0, 19) == 0) s = '1;
          put(KIND_TICK, s, POS_W'($urandom));
        end
        repeat ($urandom_range(1, 3)) put(KIND_TICK, '1, POS_W'($urandom));
        if (route.size() > 0 && route[0] == cab) void'(route.pop_front());
        if (route.size() > 0) begin
          if (route[0] > cab) cab++;
          else if (route[0] < cab) cab--;
        end else if (cab == 0) begin
          cab = 1;
        end else if (cab == LEVELS - 1 || $urandom_range(0, 1) == 0) begin
          cab--;
        end else begin
          cab++;
        end
      end
    end
  endtask

  task automatic wait_idle();
    while (pending_beats.size() != 0 || s_valid || want_status_q.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_debounce(input logic [DBNC_W-1:0] v);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    dbnc_m     = v;
    cfg_writes++;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  // driver
  always @(negedge clk_i) begin
    if (rst_ni && (!s_valid || beat_done)) begin
      beat_done = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
        s_valid <= 1'b0;
      end else if (pending_beats.size() > 0) begin
        cur = pending_beats.pop_front();
        s_valid <= 1'b1;
        s_tdata <= S_TDATA_W'({cur.target, cur.sensors});
        s_tuser <= cur.kind;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        s_valid <= 1'b0;
      end
    end
  end

  // receiver
  always @(negedge clk_i) begin
    rx_cyc++;
    if (!hold_done && beats_in >= HOLD_AFTER) begin
      hold_left = HOLD_CYCLES;
      hold_done = 1'b1;
    end
    if (rx_cyc % 50 == 0) rx_mode = rx_mode_e'($urandom_range(0, 3));
    if (!rst_ni) begin
      m_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_ready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_OPEN:     m_ready <= 1'b1;
        RX_COIN:     m_ready <= 1'($urandom_range(0, 1));
        RX_MOSTLY:   m_ready <= ($urandom_range(0, 3) != 0);
        RX_PERIODIC: m_ready <= (rx_cyc % 7 >= 2);
        default:     m_ready <= 1'b1;
      endcase
    end
  end

  // input acceptance, stall tracking and watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_valid && s_ready) begin
        advance_lift(cur);
        beats_in++;
        beat_done = 1'b1;
      end
      if (s_valid && !s_ready) begin
        stall_run++;
        if (stall_run > stall_max) stall_max = stall_run;
      end else begin
        stall_run = 0;
      end
      if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cyc = 0;
      else idle_cyc++;
      if (idle_cyc >= WATCHDOG_LIMIT) begin
        $display("tb_top: no beat for %0d cycles", idle_cyc);
        $display("tb_top: errors");
        $finish;
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    status_t got, want;
    if (rst_ni && m_valid && m_ready) begin
      got = status_t'(m_tdata);
      results_out++;
      if (got.arrived) arrivals++;
      if (got.dropped) drops++;
      if (want_status_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= MAX_REPORTS) $display("tb_top: result %0d with none pending", results_out);
      end else begin
        want = want_status_q.pop_front();
        if (got.motor_run !== want.motor_run || got.motor_up !== want.motor_up ||
            got.leds !== want.leds || got.pos_from !== want.pos_from ||
            got.pos_to !== want.pos_to || got.qcount !== want.qcount ||
            got.arrived !== want.arrived || got.dropped !== want.dropped) begin
          err_cnt++;
          if (err_cnt <= MAX_REPORTS) begin
            $display("tb_top: result %0d want run=%0b up=%0b leds=%02h from=%0d to=%0d q=%0d arr=%0b drop=%0b",
                     results_out, want.motor_run, want.motor_up, want.leds, want.pos_from,
                     want.pos_to, want.qcount, want.arrived, want.dropped);
            $display("tb_top: result %0d got  run=%0b up=%0b leds=%02h from=%0d to=%0d q=%0d arr=%0b drop=%0b",
                     results_out, got.motor_run, got.motor_up, got.leds, got.pos_from,
                     got.pos_to, got.qcount, got.arrived, got.dropped);
          end
        end
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset debounce: reserved kind, fill past full, sensor extremes, clear
    put(KIND_RSVD, 8'h00, 3'd7);
    for (int t = 0; t < QUEUE_DEPTH; t++) put(KIND_ENQ, 8'hFF, POS_W'(t ^ 7));
    put(KIND_ENQ, 8'h00, 3'd5);
    put(KIND_TICK, 8'h00, 3'd0);
    put(KIND_TICK, 8'hFF, 3'd7);
    put(KIND_TICK, 8'hAA, 3'd2);
    put(KIND_TICK, 8'h55, 3'd5);
    put(KIND_CLEAR, 8'h5A, 3'd3);
    put(KIND_ENQ, 8'hA5, 3'd7);
    wait_idle();

    // all levels arrive on one tick, then release at both ends
    write_debounce(8'd1);
    put(KIND_TICK, 8'h00, 3'd0);
    put(KIND_TICK, 8'h00, 3'd0);
    put(KIND_TICK, 8'hFF, 3'd0);
    put(KIND_ENQ, 8'h00, 3'd0);
    put(KIND_TICK, 8'hFE, 3'd0);
    put(KIND_TICK, 8'hFE, 3'd0);
    put(KIND_TICK, 8'hFF, 3'd0);
    put(KIND_TICK, 8'h7F, 3'd0);
    put(KIND_TICK, 8'h7F, 3'd0);
    put(KIND_TICK, 8'hFF, 3'd0);
    wait_idle();

    cab = 0;
    run_trips(32);
    wait_idle();
    write_debounce(8'd2);
    run_trips(32);
    wait_idle();
    write_debounce(8'd5);
    run_trips(32);
    wait_idle();
    write_debounce(8'd3);
    run_trips(32);
    wait_idle();
    write_debounce(DBNC_W'($urandom_range(1, 6)));
    run_trips(32);
    wait_idle();

    // debounce at its top: low time must saturate and still arrive
    write_debounce(8'd255);
    put(KIND_ENQ, 8'h00, 3'd3);
    repeat (260) put(KIND_TICK, 8'hF7, POS_W'($urandom));
    repeat (2) put(KIND_TICK, 8'hFF, POS_W'($urandom));
    wait_idle();

    repeat (8) @(posedge clk_i);
    $display("tb_top: %0d beats in, %0d results, %0d arrivals, %0d dropped requests",
             beats_in, results_out, arrivals, drops);
    $display("tb_top: %0d debounce writes, longest input stall %0d cycles, %0d mismatches",
             cfg_writes, stall_max, err_cnt);
    if (err_cnt == 0 && want_status_q.size() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl/core
rtl/core/lpdc_pkg.sv
rtl/core/lift_position_and_drive_control.sv
rtl/core/lpdc_checker.sv
tb/tb_top.sv
